FILE: rtl/rotary_knob_duty_control_core_macros.svh
// Assertion macros for the rotary knob duty control core.
// Used by the top level only; no other dependencies.
`ifndef ROTARY_KNOB_DUTY_CONTROL_CORE_MACROS_SVH
`define ROTARY_KNOB_DUTY_CONTROL_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RKD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define RKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RKD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define RKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/rkd_pkg.sv
// Shared types and constants for the rotary knob duty control core.
// No dependencies.
package rkd_pkg;

    localparam int DUTY_W     = 8;
    localparam int STEP_W     = 7;
    localparam int DEBOUNCE_W = 16;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

    // step_dir codes
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BWD  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_STEP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CEILING  = 2'd3;

    // register reset values
    localparam logic [STEP_W-1:0]     KNOB_STEP_RST      = 7'd4;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TICKS_RST = 16'd1000;
    localparam logic [STEP_W-1:0]     PRESS_STEP_RST     = 7'd4;
    localparam logic [DUTY_W-1:0]     PRESS_CEILING_RST  = 8'd240;

    typedef struct packed {
        logic [STEP_W-1:0]     knob_step;
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [STEP_W-1:0]     press_step;
        logic [DUTY_W-1:0]     press_ceiling;
    } rkd_cfg_t;

    typedef struct packed {
        logic button_pin;
        logic pin_b;
        logic pin_a;
    } rkd_pins_t;

endpackage

FILE: rtl/rkd_quad.sv
// Quadrature decoder and saturating knob duty register.
// Depends on rkd_pkg.
module rkd_quad (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic                        pin_a,
    input  logic                        pin_b,
    input  logic [rkd_pkg::STEP_W-1:0]  knob_step,
    output logic [rkd_pkg::DUTY_W-1:0]  knob_next,
    output logic [rkd_pkg::DIR_W-1:0]   dir_next
);

    logic [1:0]                 prior_code_reg;
    logic                       primed_reg;
    logic [rkd_pkg::DUTY_W-1:0] knob_reg;
    logic [1:0]                 code;
    logic [rkd_pkg::DUTY_W:0]   sum;
    logic [rkd_pkg::DUTY_W-1:0] step_ext;

    // Binary position from the Gray-coded pins: high bit is A, low bit is A xor B
    assign code     = {pin_a, pin_a ^ pin_b};
    assign step_ext = {1'b0, knob_step};
    assign sum      = {1'b0, knob_reg} + {2'b00, knob_step};

    always_comb begin
        dir_next = rkd_pkg::DIR_NONE;
        if (primed_reg) begin
            if ((code + 2'd1) == prior_code_reg) begin
                dir_next = rkd_pkg::DIR_BWD;
            end else if ((prior_code_reg + 2'd1) == code) begin
                dir_next = rkd_pkg::DIR_FWD;
            end
        end
    end

    always_comb begin
        knob_next = knob_reg;
        if (dir_next == rkd_pkg::DIR_FWD) begin
            knob_next = sum[rkd_pkg::DUTY_W] ? rkd_pkg::DUTY_MAX : sum[rkd_pkg::DUTY_W-1:0];
        end else if (dir_next == rkd_pkg::DIR_BWD) begin
            knob_next = (knob_reg >= step_ext) ? (knob_reg - step_ext) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_code_reg <= '0;
            primed_reg     <= 1'b0;
            knob_reg       <= '0;
        end else if (step_en) begin
            prior_code_reg <= code;
            primed_reg     <= 1'b1;
            knob_reg       <= knob_next;
        end
    end

endmodule

FILE: rtl/rkd_button.sv
// Button debouncer and press-driven duty register.
// Depends on rkd_pkg.
module rkd_button (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step_en,
    input  logic                            button_pin,
    input  logic [rkd_pkg::DEBOUNCE_W-1:0]  debounce_ticks,
    input  logic [rkd_pkg::STEP_W-1:0]      press_step,
    input  logic [rkd_pkg::DUTY_W-1:0]      press_ceiling,
    output logic [rkd_pkg::DUTY_W-1:0]      button_next
);

    logic                           last_pressed_reg, last_pressed_next;
    logic [rkd_pkg::DEBOUNCE_W-1:0] stable_count_reg, stable_count_next;
    logic                           handled_reg, handled_next;
    logic [rkd_pkg::DUTY_W-1:0]     button_reg;
    logic                           pressed;
    logic [rkd_pkg::DUTY_W:0]       sum;

    assign pressed = ~button_pin;
    assign sum     = {1'b0, button_reg} + {2'b00, press_step};

    always_comb begin
        last_pressed_next = last_pressed_reg;
        stable_count_next = stable_count_reg;
        handled_next      = handled_reg;
        button_next       = button_reg;
        priority if (pressed != last_pressed_reg) begin
            stable_count_next = '0;
            handled_next      = 1'b0;
            last_pressed_next = pressed;
        end else if (stable_count_reg < debounce_ticks) begin
            stable_count_next = stable_count_reg + 1'b1;
        end else if (!handled_reg) begin
            // level is settled: act on it once
            handled_next = 1'b1;
            if (pressed && (button_reg < press_ceiling)) begin
                button_next = sum[rkd_pkg::DUTY_W] ? rkd_pkg::DUTY_MAX
                                                   : sum[rkd_pkg::DUTY_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pressed_reg <= 1'b0;
            stable_count_reg <= '0;
            handled_reg      <= 1'b0;
            button_reg       <= '0;
        end else if (step_en) begin
            last_pressed_reg <= last_pressed_next;
            stable_count_reg <= stable_count_next;
            handled_reg      <= handled_next;
            button_reg       <= button_next;
        end
    end

endmodule

FILE: rtl/rotary_knob_duty_control_core.sv
// Path: an accepted transaction waits in the input register, then moves to the result register on m_tdata.
// Throughput: one transaction per cycle while m_tready is high; when a result waits for
// m_tready the input register takes one more transaction, then s_tready drops.
// Reset: aresetn is synchronous, active low; it clears both registers' valid bits,
// the decoder and debounce state, both duties, and loads register defaults.
// Depends on rkd_pkg, rkd_quad, rkd_button and the macros header.
`include "rotary_knob_duty_control_core_macros.svh"

module rotary_knob_duty_control_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] pin_a, [1] pin_b, [2] button_pin, [7:3] zero
    input  logic [rkd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] knob_duty, [15:8] button_duty, [17:16] step_dir, [23:18] zero
    output logic [rkd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [rkd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rkd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    rkd_pkg::rkd_cfg_t  cfg_reg;
    rkd_pkg::rkd_pins_t pins_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;

    logic [rkd_pkg::DUTY_W-1:0] knob_next, button_next;
    logic [rkd_pkg::DIR_W-1:0]  dir_next;
    logic [rkd_pkg::DUTY_W-1:0] knob_out_reg, button_out_reg;
    logic [rkd_pkg::DIR_W-1:0]  dir_out_reg;

    // item moves from input register to result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.knob_step      <= rkd_pkg::KNOB_STEP_RST;
            cfg_reg.debounce_ticks <= rkd_pkg::DEBOUNCE_TICKS_RST;
            cfg_reg.press_step     <= rkd_pkg::PRESS_STEP_RST;
            cfg_reg.press_ceiling  <= rkd_pkg::PRESS_CEILING_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rkd_pkg::REG_KNOB_STEP:
                    cfg_reg.knob_step <= cfg_wdata[rkd_pkg::STEP_W-1:0];
                rkd_pkg::REG_DEBOUNCE_TICKS:
                    cfg_reg.debounce_ticks <= cfg_wdata[rkd_pkg::DEBOUNCE_W-1:0];
                rkd_pkg::REG_PRESS_STEP:
                    cfg_reg.press_step <= cfg_wdata[rkd_pkg::STEP_W-1:0];
                rkd_pkg::REG_PRESS_CEILING:
                    cfg_reg.press_ceiling <= cfg_wdata[rkd_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pins_reg <= s_tdata[2:0];
        end
        if (advance) begin
            knob_out_reg   <= knob_next;
            button_out_reg <= button_next;
            dir_out_reg    <= dir_next;
        end
    end

    rkd_quad u_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .pin_a     (pins_reg.pin_a),
        .pin_b     (pins_reg.pin_b),
        .knob_step (cfg_reg.knob_step),
        .knob_next (knob_next),
        .dir_next  (dir_next)
    );

    rkd_button u_button (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .button_pin     (pins_reg.button_pin),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .press_step     (cfg_reg.press_step),
        .press_ceiling  (cfg_reg.press_ceiling),
        .button_next    (button_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, dir_out_reg, button_out_reg, knob_out_reg};

    `RKD_ASSERT_IMPLY(a_dir_legal, aclk, aresetn, m_tvalid, m_tdata[17:16] != 2'b11, "illegal step_dir code")
    `RKD_ASSERT_IMPLY(a_ready_when_drained, aclk, aresetn, !m_tvalid, s_tready, "input stalled with result register empty")
    `RKD_ASSERT_NEXT(a_result_follows, aclk, aresetn, advance, m_tvalid, "moved item did not reach result register")
    `RKD_ASSERT_IMPLY(a_first_no_step, aclk, aresetn, !u_quad.primed_reg, dir_next == rkd_pkg::DIR_NONE, "step decoded before first code recorded")

endmodule

FILE: tb/rotary_knob_duty_control_core_checker.sv
// Checker for rotary_knob_duty_control_core: tracks register writes, predicts each result
// from the accepted input transactions and compares the result stream field by field.
// Depends on rkd_pkg.
module rotary_knob_duty_control_core_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rkd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rkd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [rkd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rkd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rkd_pkg::*;

    typedef struct packed {
        logic [DUTY_W-1:0] knob;
        logic [DUTY_W-1:0] button;
        logic [DIR_W-1:0]  dir;
    } duty_result_t;

    // register copies
    logic [STEP_W-1:0]     knob_step_r;
    logic [DEBOUNCE_W-1:0] debounce_r;
    logic [STEP_W-1:0]     press_step_r;
    logic [DUTY_W-1:0]     ceiling_r;

    // decoder and debounce state
    logic [1:0]            prior_pos;
    logic                  pos_seen;
    logic [DUTY_W-1:0]     knob_duty_q;
    logic [DUTY_W-1:0]     button_duty_q;
    logic                  held_pressed;
    logic [DEBOUNCE_W-1:0] stable_ticks;
    logic                  level_taken;

    duty_result_t expected_duties[$];
    duty_result_t want;
    int errors = 0;

    assign fail_count = errors;
    initial pending = 0;

    function automatic duty_result_t predict_tick(input logic pin_a, input logic pin_b,
                                                  input logic button_pin);
        logic [1:0]        pos;
        logic [1:0]        pos_next;
        logic [1:0]        prior_next;
        logic [DIR_W-1:0]  dir;
        logic              pressed;
        logic [DUTY_W:0]   sum;
        duty_result_t      r;
        pos = {pin_a, pin_a ^ pin_b};
        pos_next = pos + 2'd1;
        prior_next = prior_pos + 2'd1;
        dir = DIR_NONE;
        pressed = !button_pin;
        if (pos_seen) begin
            if (pos_next == prior_pos)
                dir = DIR_BWD;
            else if (prior_next == pos)
                dir = DIR_FWD;
        end
        prior_pos = pos;
        pos_seen = 1'b1;

        if (dir == DIR_FWD) begin
            sum = {1'b0, knob_duty_q} + {2'b00, knob_step_r};
            knob_duty_q = (sum > DUTY_MAX) ? DUTY_MAX : sum[DUTY_W-1:0];
        end else if (dir == DIR_BWD) begin
            knob_duty_q = (knob_duty_q >= knob_step_r) ? knob_duty_q - knob_step_r : '0;
        end

        if (pressed != held_pressed) begin
            stable_ticks = '0;
            level_taken = 1'b0;
            held_pressed = pressed;
        end else if (stable_ticks < debounce_r) begin
            stable_ticks = stable_ticks + 1'b1;
        end else if (!level_taken) begin
            // a released level only marks itself as handled
            level_taken = 1'b1;
            if (pressed && button_duty_q < ceiling_r) begin
                sum = {1'b0, button_duty_q} + {2'b00, press_step_r};
                button_duty_q = (sum > DUTY_MAX) ? DUTY_MAX : sum[DUTY_W-1:0];
            end
        end

        r.knob = knob_duty_q;
        r.button = button_duty_q;
        r.dir = dir;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            knob_step_r = KNOB_STEP_RST;
            debounce_r = DEBOUNCE_TICKS_RST;
            press_step_r = PRESS_STEP_RST;
            ceiling_r = PRESS_CEILING_RST;
            prior_pos = 2'd0;
            pos_seen = 1'b0;
            knob_duty_q = '0;
            button_duty_q = '0;
            held_pressed = 1'b0;
            stable_ticks = '0;
            level_taken = 1'b0;
            expected_duties.delete();
        end else begin
            // result of an earlier transaction is checked before this edge's input is added
            if (m_tvalid && m_tready) begin
                if (expected_duties.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual m_tdata %h",
                             $time, m_tdata);
                end else begin
                    want = expected_duties.pop_front();
                    if (m_tdata[7:0] !== want.knob) begin
                        errors++;
                        $display("%0t: knob_duty expected %0d actual %0d",
                                 $time, want.knob, m_tdata[7:0]);
                    end
                    if (m_tdata[15:8] !== want.button) begin
                        errors++;
                        $display("%0t: button_duty expected %0d actual %0d",
                                 $time, want.button, m_tdata[15:8]);
                    end
                    if (m_tdata[17:16] !== want.dir) begin
                        errors++;
                        $display("%0t: step_dir expected %0d actual %0d",
                                 $time, want.dir, m_tdata[17:16]);
                    end
                    if (m_tdata[23:18] !== 6'd0) begin
                        errors++;
                        $display("%0t: m_tdata padding expected 0 actual %h",
                                 $time, m_tdata[23:18]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_duties.push_back(predict_tick(s_tdata[0], s_tdata[1], s_tdata[2]));
            if (cfg_we) begin
                case (cfg_index)
                    REG_KNOB_STEP:      knob_step_r = cfg_wdata[STEP_W-1:0];
                    REG_DEBOUNCE_TICKS: debounce_r = cfg_wdata;
                    REG_PRESS_STEP:     press_step_r = cfg_wdata[STEP_W-1:0];
                    REG_PRESS_CEILING:  ceiling_r = cfg_wdata[DUTY_W-1:0];
                    default: ;
                endcase
            end
        end
        pending <= expected_duties.size();
    end

endmodule

FILE: tb/rotary_knob_duty_control_core_tb.sv
// Top testbench for rotary_knob_duty_control_core: drives directed and random encoder and
// button ticks plus register settings, with random stalls on both channels.
// Depends on rkd_pkg, the core and rotary_knob_duty_control_core_checker.
module rotary_knob_duty_control_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rkd_pkg::*;

    localparam int LIMIT_CYCLES = 300000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [0] pin_a, [1] pin_b, [2] button_pin, [7:3] zero
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [7:0] knob_duty, [15:8] button_duty, [17:16] step_dir, [23:18] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    int unsigned rx_left = 0;
    logic        stalls_on = 1'b1;
    logic [1:0]  knob_pos = 2'd0;

    rotary_knob_duty_control_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rotary_knob_duty_control_core_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: bursts of stall and ready
    always @(posedge aclk) begin
        if (!stalls_on) begin
            m_tready <= 1'b1;
            rx_left <= 0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            rx_left <= $urandom_range(0, 13);
        end else begin
            m_tready <= 1'b1;
            rx_left <= $urandom_range(0, 19);
        end
    end

    // one tick: move the position code by delta, then hold until the transaction is taken
    task automatic move(input logic [1:0] delta, input logic button_pin);
        logic [1:0] pos;
        pos = knob_pos + delta;
        knob_pos = pos;
        if (stalls_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tdata <= {5'b00000, button_pin, pos[1] ^ pos[0], pos[1]};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    task automatic load_regs(input int unsigned k, input int unsigned d, input int unsigned p,
                             input int unsigned c);
        settle();
        write_reg(REG_KNOB_STEP, CFG_DATA_W'(k));
        write_reg(REG_DEBOUNCE_TICKS, CFG_DATA_W'(d));
        write_reg(REG_PRESS_STEP, CFG_DATA_W'(p));
        write_reg(REG_PRESS_CEILING, CFG_DATA_W'(c));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int unsigned pick_step();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 127;
            3: return 64;
            default: return $urandom_range(1, 127);
        endcase
    endfunction

    initial begin
        int unsigned n_items;
        int unsigned deb;
        int unsigned fwd_pct;
        int unsigned run_left;
        int unsigned r;
        logic        btn;
        logic [1:0]  delta;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: first tick only records, three steps forward, a full turn back to the floor, jumps
        move(2'd1, 1'b1);
        move(2'd1, 1'b1);
        move(2'd1, 1'b0);
        move(2'd1, 1'b0);
        move(2'd0, 1'b1);
        move(2'd3, 1'b1);
        move(2'd3, 1'b1);
        move(2'd3, 1'b1);
        move(2'd3, 1'b1);
        move(2'd2, 1'b1);
        move(2'd2, 1'b1);
        move(2'd1, 1'b1);

        // debounce limit dropped below the running count
        load_regs(1, 10, 5, 100);
        move(2'd1, 1'b1);
        move(2'd1, 1'b0);
        repeat (6) move(2'd0, 1'b0);
        load_regs(1, 2, 5, 100);
        move(2'd3, 1'b0);

        // zero steps
        load_regs(0, 0, 0, 255);
        move(2'd1, 1'b1);
        move(2'd3, 1'b0);
        move(2'd0, 1'b0);
        move(2'd1, 1'b0);

        // ceiling at zero, longest debounce
        load_regs(64, 65535, 64, 0);
        move(2'd1, 1'b1);
        move(2'd3, 1'b0);
        move(2'd0, 1'b0);

        // largest steps: knob saturates both ways
        load_regs(127, 0, 127, 255);
        move(2'd1, 1'b1);
        move(2'd1, 1'b0);
        move(2'd1, 1'b0);
        move(2'd3, 1'b1);
        move(2'd3, 1'b1);
        move(2'd3, 1'b1);

        // random phases; the last one runs without stalls and forces button saturation
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 11) begin
                deb = 2;
                load_regs(pick_step(), deb, 127, 255);
            end else begin
                case ($urandom_range(0, 7))
                    0: deb = 0;
                    1: deb = 65535;
                    2: deb = 1000;
                    default: deb = $urandom_range(1, 15);
                endcase
                r = $urandom_range(0, 3);
                load_regs(pick_step(), deb, pick_step(),
                          (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255));
            end
            stalls_on = (ph != 11) && ($urandom_range(0, 3) != 0);
            n_items = $urandom_range(110, 180);
            fwd_pct = $urandom_range(20, 80);
            btn = 1'($urandom_range(0, 1));
            run_left = 0;
            for (int i = 0; i < n_items; i++) begin
                if (run_left == 0) begin
                    btn = !btn;
                    if (deb > 40)
                        run_left = $urandom_range(1, 60);
                    else if ($urandom_range(0, 4) == 0)
                        run_left = $urandom_range(1, 3);
                    else
                        run_left = $urandom_range(deb + 1, deb + 8);
                end
                run_left--;
                r = $urandom_range(0, 99);
                if (r < 75)
                    delta = ($urandom_range(0, 99) < fwd_pct) ? 2'd1 : 2'd3;
                else if (r < 85)
                    delta = 2'd0;
                else if (r < 93)
                    delta = 2'd2;
                else
                    delta = 2'($urandom_range(0, 3));
                move(delta, btn);
            end
        end

        settle();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: rotary_knob_duty_control_core.f
+incdir+rtl
rtl/rkd_pkg.sv
rtl/rkd_quad.sv
rtl/rkd_button.sv
rtl/rotary_knob_duty_control_core.sv
tb/rotary_knob_duty_control_core_checker.sv
tb/rotary_knob_duty_control_core_tb.sv
